### sv/hwcfs_pkg.sv
// hwcfs_pkg: shared types and constants for the wall contact force sum block.
// No dependencies.
`default_nettype none
package hwcfs_pkg;
  localparam int COORD_W = 32;
  localparam int HALF_W = 31;
  localparam int STIFF_W = 32;
  localparam int SUM_W = 63;
  localparam int AXES = 3;
  localparam int ROOT_W = 24;
  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;
  localparam int BITS_PER_CYCLE = 2;
  localparam int ROOT_CYCLES = ROOT_W / BITS_PER_CYCLE;
  localparam int ROOT_CNT_W = $clog2(ROOT_CYCLES);
  localparam int PROD_W = HALF_W + ROOT_W;
  localparam int PHI_W = PROD_W - 32;
  localparam int LO_W = STIFF_W + 32;
  localparam int HI_W = STIFF_W + PHI_W;
  localparam int CFG_IDX_W = 3;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_HALF_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STIFF = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PERIODIC = 3'd5;

  typedef struct packed {
    logic [AXES-1:0][HALF_W-1:0] half;
    logic [HALF_W-1:0] radius;
    logic [STIFF_W-1:0] stiff;
    logic periodic;
  } cfg_t;

  typedef struct packed {
    logic [AXES-1:0][HALF_W-1:0] h;
    logic [AXES-1:0] pos;
    logic last;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;
endpackage
`default_nettype wire

### sv/hertz_wall_contact_force_sum.sv
// hertz_wall_contact_force_sum: top level, configuration registers and wiring.
// Depends on hwcfs_pkg, hwcfs_front, hwcfs_queue, hwcfs_back.
//
// Vertices arrive on in_valid/in_stall with coord_x/y/z and last_vertex; a
// request is taken when in_valid is high and in_stall low. Each vertex is
// classified at once and held in a two-entry queue; in_stall rises only
// when that queue is full. The sequencer works on one vertex at a time:
// for every axis with positive overlap it runs the shared root unit (two
// root bits a cycle) and then the two multiplies by the 32-bit stiffness.
// On a vertex with last_vertex set, the total is loaded into the result
// register once that register is free, and the sum clears; out_valid is
// registered. The result register holds while out_stall is high; the next
// vertex is still worked and waits only at its own result. Configuration
// writes (cfg_valid, cfg_ready tied high, cfg_index, cfg_data) are taken at
// any time but belong to idle periods. Synchronous reset clears the
// configuration registers, the queue, the sequencer state, out_valid and
// the sum.
`default_nettype none
module hertz_wall_contact_force_sum import hwcfs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [COORD_W-1:0] coord_x,
  input  wire logic [COORD_W-1:0] coord_y,
  input  wire logic [COORD_W-1:0] coord_z,
  input  wire logic last_vertex,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [SUM_W-1:0] force_total,
  output logic saturated
);
  cfg_t cfg;
  entry_t entry, q_data;
  q_status_t q_status;
  logic pop;

  assign cfg_ready = 1'b1;
  assign in_stall = q_status.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HALF_X:   cfg.half[0] <= cfg_data[HALF_W-1:0];
        REG_HALF_Y:   cfg.half[1] <= cfg_data[HALF_W-1:0];
        REG_HALF_Z:   cfg.half[2] <= cfg_data[HALF_W-1:0];
        REG_RADIUS:   cfg.radius <= cfg_data[HALF_W-1:0];
        REG_STIFF:    cfg.stiff <= cfg_data;
        REG_PERIODIC: cfg.periodic <= cfg_data[0];
        default: ;
      endcase
    end
  end

  hwcfs_front u_front (
    .cfg(cfg), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .last_vertex(last_vertex), .entry(entry)
  );

  hwcfs_queue u_queue (
    .clk(clk), .rst(rst), .push(in_valid && !q_status.full), .push_data(entry),
    .pop(pop), .pop_data(q_data), .status(q_status)
  );

  hwcfs_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_status(q_status), .q_data(q_data),
    .pop(pop), .out_valid(out_valid), .out_stall(out_stall),
    .force_total(force_total), .saturated(saturated)
  );
endmodule
`default_nettype wire

### sv/hwcfs_front.sv
// hwcfs_front: classifies one vertex into per-axis overlaps.
// Depends on hwcfs_pkg.
`default_nettype none
module hwcfs_front import hwcfs_pkg::*; (
  input  wire cfg_t cfg,
  input  wire logic [COORD_W-1:0] coord_x,
  input  wire logic [COORD_W-1:0] coord_y,
  input  wire logic [COORD_W-1:0] coord_z,
  input  wire logic last_vertex,
  output entry_t entry
);
  logic [AXES-1:0][COORD_W-1:0] c;
  logic [AXES-1:0][COORD_W-1:0] mag;
  logic [AXES-1:0][COORD_W-1:0] gap;
  logic [AXES-1:0][COORD_W-1:0] half;
  logic [COORD_W-1:0] rad;

  assign c[0] = coord_x;
  assign c[1] = coord_y;
  assign c[2] = coord_z;
  assign rad = {1'b0, cfg.radius};

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      half[a] = {1'b0, cfg.half[a]};
      mag[a] = c[a][COORD_W-1] ? (~c[a] + 32'd1) : c[a];
      gap[a] = (mag[a] >= half[a]) ? (mag[a] - half[a]) : (half[a] - mag[a]);
      entry.pos[a] = !cfg.periodic && (rad > gap[a]);
      entry.h[a] = HALF_W'(rad - gap[a]);
    end
    entry.last = last_vertex;
  end
endmodule
`default_nettype wire

### sv/hwcfs_queue.sv
// hwcfs_queue: two-entry queue between classifier and sequencer.
// Depends on hwcfs_pkg.
`default_nettype none
module hwcfs_queue import hwcfs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire entry_t push_data,
  input  wire logic pop,
  output entry_t pop_data,
  output q_status_t status
);
  entry_t slot [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;

  assign pop_data = slot[rd_ptr];
  assign status.valid = count != 2'd0;
  assign status.full = count == 2'd2;

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

### sv/hwcfs_sqrt.sv
// hwcfs_sqrt: iterative integer square root of h << 16, two bits a cycle.
// Depends on hwcfs_pkg.
`default_nettype none
module hwcfs_sqrt import hwcfs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [HALF_W-1:0] h,
  output logic busy,
  output logic done,
  output logic [ROOT_W-1:0] root
);
  logic [RAD_W-1:0] v, v_next;
  logic [REM_W-1:0] rem, rem_next;
  logic [ROOT_W-1:0] root_next;
  logic [ROOT_CNT_W-1:0] count;

  always_comb begin
    logic [REM_W+1:0] r4;
    logic [REM_W+1:0] trial;
    v_next = v;
    rem_next = rem;
    root_next = root;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      r4 = {rem_next, v_next[RAD_W-1 -: 2]};
      trial = {2'b00, root_next, 2'b01};
      if (r4 >= trial) begin
        rem_next = REM_W'(r4 - trial);
        root_next = {root_next[ROOT_W-2:0], 1'b1};
      end else begin
        rem_next = REM_W'(r4);
        root_next = {root_next[ROOT_W-2:0], 1'b0};
      end
      v_next = {v_next[RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v <= {1'b0, h, 16'h0000};
      rem <= '0;
      root <= '0;
    end else if (busy) begin
      v <= v_next;
      rem <= rem_next;
      root <= root_next;
    end
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && (count == ROOT_CNT_W'(ROOT_CYCLES - 1));
      if (start) begin
        busy <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == ROOT_CNT_W'(ROOT_CYCLES - 1)) busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

### sv/hwcfs_back.sv
// hwcfs_back: per-axis sequencer, force term, saturating sum, result register.
// Depends on hwcfs_pkg and hwcfs_sqrt.
`default_nettype none
module hwcfs_back import hwcfs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire q_status_t q_status,
  input  wire entry_t q_data,
  output logic pop,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [SUM_W-1:0] force_total,
  output logic saturated
);
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_PICK = 9'b000000010,
    S_ROOT = 9'b000000100,
    S_MLO  = 9'b000001000,
    S_MHI  = 9'b000010000,
    S_TERM = 9'b000100000,
    S_ACC  = 9'b001000000,
    S_DONE = 9'b010000000,
    S_WAIT = 9'b100000000
  } state_t;

  state_t state, state_next;
  entry_t ent;
  logic [1:0] axis;
  logic [HALF_W-1:0] h_cur;
  logic [PROD_W-1:0] p;
  logic [LO_W-1:0] lo;
  logic [HI_W-1:0] hi;
  logic [SUM_W-1:0] term, sum;
  logic ovf;
  logic root_start, root_busy, root_done, load;
  logic [ROOT_W-1:0] root;
  logic [SUM_W:0] t_wide, s_wide;

  assign h_cur = (axis == 2'(AXES)) ? '0 : ent.h[axis];
  assign pop = (state == S_IDLE) && q_status.valid;
  assign root_start = (state == S_PICK) && (axis != 2'(AXES)) && ent.pos[axis];
  assign load = (state == S_DONE) && ent.last && (!out_valid || !out_stall);
  assign t_wide = {1'b0, hi[46:0], 16'h0000} + (SUM_W+1)'(lo[LO_W-1:16]);
  assign s_wide = {1'b0, sum} + {1'b0, term};

  hwcfs_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(root_start), .h(h_cur),
    .busy(root_busy), .done(root_done), .root(root)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (q_status.valid) state_next = S_PICK;
      S_PICK: begin
        if (axis == 2'(AXES)) state_next = S_DONE;
        else if (ent.pos[axis]) state_next = S_ROOT;
      end
      S_ROOT: if (root_done) state_next = S_MLO;
      S_MLO:  state_next = S_MHI;
      S_MHI:  state_next = S_TERM;
      S_TERM: state_next = S_ACC;
      S_ACC:  state_next = S_PICK;
      S_DONE: begin
        if (!ent.last || load) state_next = S_IDLE;
        else state_next = S_WAIT;
      end
      S_WAIT: state_next = S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) ent <= q_data;
    if (state == S_ROOT && root_done) p <= PROD_W'(h_cur * root);
    if (state == S_MLO) lo <= cfg.stiff * p[31:0];
    if (state == S_MHI) hi <= HI_W'(cfg.stiff * p[PROD_W-1:32]);
    if (state == S_TERM) begin
      if (hi[HI_W-1:47] != '0 || t_wide[SUM_W] || t_wide[SUM_W-1:0] == SUM_MAX) term <= SUM_MAX;
      else term <= t_wide[SUM_W-1:0];
    end
    if (load) begin
      force_total <= cfg.periodic ? '0 : sum;
      saturated <= cfg.periodic ? 1'b0 : ovf;
    end
    if (rst) begin
      state <= S_IDLE;
      axis <= '0;
      sum <= '0;
      ovf <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) axis <= '0;
      else if ((state == S_PICK && axis != 2'(AXES) && !ent.pos[axis]) || state == S_ACC)
        axis <= axis + 1'b1;
      if (state == S_ACC) begin
        if (s_wide[SUM_W] || s_wide[SUM_W-1:0] == SUM_MAX) begin
          sum <= SUM_MAX;
          ovf <= 1'b1;
        end else begin
          sum <= s_wide[SUM_W-1:0];
        end
      end
      if (load) begin
        sum <= '0;
        ovf <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_ovf_sum: assert property (@(posedge clk) disable iff (rst) ovf |-> sum == SUM_MAX)
    else $error("overflow flag without saturated sum");
  a_root_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT && !root_done) |-> root_busy)
    else $error("waiting on idle root unit");
  a_axis_range: assert property (@(posedge clk) disable iff (rst) axis <= 2'(AXES))
    else $error("axis counter out of range");
  a_load_out: assert property (@(posedge clk) disable iff (rst) load |=> out_valid && sum == '0)
    else $error("result load lost");
endmodule
`default_nettype wire
